// File: sv/alliw_pkg.sv
// Package for the array-backed linked list: sizes, codes, payload and
// control structs. No dependencies.
package alliw_pkg;

   localparam int NODES = 16;
   localparam int SLOT_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);
   localparam int SLOT_FIELD_W = 4;

   typedef enum logic [1:0] {
      CMD_HEAD  = 2'd0,
      CMD_AFTER = 2'd1,
      CMD_TAIL  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_FULL = 2'd1,
      ERR_PRED = 2'd2
   } err_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [3:0]              after_slot;
      logic signed [31:0]      price;
      logic [63:0]             name_code;
      logic [7:0]              status_code;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot;
      logic signed [31:0]      out_price;
      logic [63:0]             out_name;
      logic [7:0]              out_status;
      logic                    valid_res;
      err_type                 error;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic              is_end;
      logic [SLOT_W-1:0] next;
   } link_type;

   typedef struct packed {
      logic signed [31:0] price;
      logic [63:0]        name;
      logic [7:0]         status;
   } node_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK,
      ST_LINK_NEW,
      ST_LINK_PRED,
      ST_READ
   } state_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_HEAD,
      CUR_AFTER,
      CUR_NEXT
   } cur_sel_type;

   typedef enum logic [2:0] {
      RSP_OK,
      RSP_FULL,
      RSP_BAD,
      RSP_EMPTY,
      RSP_NODE
   } rsp_sel_type;

   typedef struct packed {
      logic        cap_req;
      cur_sel_type cur_sel;
      logic        n_clr;
      logic        n_inc;
      logic        head_ins;
      logic        link_new;
      logic        link_pred;
      logic        emit;
      rsp_sel_type rsp_sel;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    full;
      logic    bad_pred;
      logic    walk_stop;
      logic    out_free;
   } sts_type;

endpackage

// File: sv/alliw_dp.sv
// Datapath of the linked list: request register, head and fill count,
// link and node memories, walk cursor and result register. Uses alliw_pkg.
module alliw_dp (
   input  logic             clock,
   input  logic             reset,
   input  alliw_pkg::req_type req_data,
   input  alliw_pkg::ctl_type ctl,
   output alliw_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output alliw_pkg::rsp_type rsp_data
);
   import alliw_pkg::*;

   req_type            req_ff;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic               empty_ff, empty_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  n_ff, n_in;
   link_type           link_mem [NODES];
   link_type           link_rd_ff;
   node_type           node_mem [NODES];
   node_type           node_rd_ff;
   logic               rd_en;
   logic               link_we;
   logic [SLOT_W-1:0]  link_wa;
   link_type           link_wd;
   logic               node_we;
   node_type           node_wd;
   logic [SLOT_W-1:0]  new_slot;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign new_slot = cnt_ff[SLOT_W-1:0];

   always_comb begin
      sts.cmd       = req_ff.cmd;
      sts.empty     = empty_ff;
      sts.full      = (cnt_ff == CNT_W'(NODES));
      sts.bad_pred  = (CNT_W'(req_ff.after_slot) >= cnt_ff);
      sts.walk_stop = link_rd_ff.is_end ||
                      (CNT_W'(link_rd_ff.next) >= CNT_W'(NODES)) ||
                      (n_ff == SLOT_W'(NODES - 1));
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (ctl.cur_sel)
         CUR_HEAD:  cur_in = head_ff;
         CUR_AFTER: cur_in = SLOT_W'(req_ff.after_slot);
         CUR_NEXT:  cur_in = link_rd_ff.next;
         default:   cur_in = cur_ff;
      endcase
      rd_en = (ctl.cur_sel != CUR_HOLD);
      if (ctl.n_clr) begin
         n_in = '0;
      end else if (ctl.n_inc) begin
         n_in = n_ff + SLOT_W'(1);
      end else begin
         n_in = n_ff;
      end
   end

   always_comb begin
      link_we = ctl.head_ins || ctl.link_new || ctl.link_pred;
      link_wa = new_slot;
      link_wd = link_rd_ff;
      if (ctl.head_ins) begin
         link_wd.is_end = empty_ff;
         link_wd.next   = empty_ff ? '0 : head_ff;
      end else if (ctl.link_pred) begin
         link_wa        = cur_ff;
         link_wd.is_end = 1'b0;
         link_wd.next   = new_slot;
      end
      node_we        = ctl.head_ins || ctl.link_new;
      node_wd.price  = req_ff.price;
      node_wd.name   = req_ff.name_code;
      node_wd.status = req_ff.status_code;
   end

   always_comb begin
      head_in  = head_ff;
      empty_in = empty_ff;
      cnt_in   = cnt_ff;
      if (ctl.head_ins) begin
         head_in  = new_slot;
         empty_in = 1'b0;
      end
      if (ctl.head_ins || ctl.link_pred) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.last = 1'b1;
      case (ctl.rsp_sel)
         RSP_OK: begin
            rsp_in.slot      = SLOT_FIELD_W'(new_slot);
            rsp_in.valid_res = 1'b1;
         end
         RSP_FULL: rsp_in.error = ERR_FULL;
         RSP_BAD:  rsp_in.error = ERR_PRED;
         RSP_NODE: begin
            rsp_in.slot       = SLOT_FIELD_W'(cur_ff);
            rsp_in.out_price  = node_rd_ff.price;
            rsp_in.out_name   = node_rd_ff.name;
            rsp_in.out_status = node_rd_ff.status;
            rsp_in.valid_res  = 1'b1;
            rsp_in.last       = sts.walk_stop;
         end
         default: rsp_in.error = ERR_NONE;
      endcase
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         empty_ff     <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cap_req) begin
         req_ff <= req_data;
      end
      if (ctl.emit) begin
         rsp_ff <= rsp_in;
      end
      cur_ff <= cur_in;
      n_ff   <= n_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[cur_in];
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[new_slot] <= node_wd;
      end
      if (rd_en) begin
         node_rd_ff <= node_mem[cur_in];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NODES))
      else $error("fill count beyond node count");

   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      empty_ff == (cnt_ff == '0))
      else $error("empty flag disagrees with fill count");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> sts.out_free)
      else $error("result loaded over a pending one");

   a_link_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.head_ins || ctl.link_pred) |-> !sts.full)
      else $error("node added to a full list");

endmodule

// File: sv/alliw_ctrl.sv
// Controller of the linked list: decodes the request and steps the walk,
// link and read out sequence. Uses alliw_pkg.
module alliw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  alliw_pkg::sts_type sts,
   output alliw_pkg::ctl_type ctl
);
   import alliw_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      ctl         = '0;
      ctl.cur_sel = CUR_HOLD;
      ctl.rsp_sel = RSP_OK;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cap_req = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.out_free) begin
               if (sts.cmd == CMD_READ) begin
                  if (sts.empty) begin
                     ctl.emit    = 1'b1;
                     ctl.rsp_sel = RSP_EMPTY;
                     state_in    = ST_IDLE;
                  end else begin
                     ctl.cur_sel = CUR_HEAD;
                     ctl.n_clr   = 1'b1;
                     state_in    = ST_READ;
                  end
               end else if (sts.full) begin
                  ctl.emit    = 1'b1;
                  ctl.rsp_sel = RSP_FULL;
                  state_in    = ST_IDLE;
               end else if (sts.cmd == CMD_HEAD || (sts.cmd == CMD_TAIL && sts.empty)) begin
                  ctl.head_ins = 1'b1;
                  ctl.emit     = 1'b1;
                  ctl.rsp_sel  = RSP_OK;
                  state_in     = ST_IDLE;
               end else if (sts.cmd == CMD_AFTER) begin
                  if (sts.bad_pred) begin
                     ctl.emit    = 1'b1;
                     ctl.rsp_sel = RSP_BAD;
                     state_in    = ST_IDLE;
                  end else begin
                     ctl.cur_sel = CUR_AFTER;
                     state_in    = ST_LINK_NEW;
                  end
               end else begin
                  ctl.cur_sel = CUR_HEAD;
                  ctl.n_clr   = 1'b1;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (sts.walk_stop) begin
               state_in = ST_LINK_NEW;
            end else begin
               ctl.cur_sel = CUR_NEXT;
               ctl.n_inc   = 1'b1;
            end
         end
         ST_LINK_NEW: begin
            ctl.link_new = 1'b1;
            state_in     = ST_LINK_PRED;
         end
         ST_LINK_PRED: begin
            if (sts.out_free) begin
               ctl.link_pred = 1'b1;
               ctl.emit      = 1'b1;
               ctl.rsp_sel   = RSP_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            if (sts.out_free) begin
               ctl.emit    = 1'b1;
               ctl.rsp_sel = RSP_NODE;
               if (sts.walk_stop) begin
                  state_in = ST_IDLE;
               end else begin
                  ctl.cur_sel = CUR_NEXT;
                  ctl.n_inc   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/array_linked_list_insert_walk_top.sv
// Top level of the array-backed singly linked list.
// Joins alliw_ctrl and alliw_dp; uses alliw_pkg.
//
//   channel  direction  payload         handshake
//   req      in         req_type        req_valid / req_ready
//   rsp      out        rsp_type        rsp_valid / rsp_ready
//
// A request is registered and decoded. Head insert, full and bad predecessor
// load their result in decode; insert after goes on through the link new and
// link pred states, and tail insert first walks to the tail. Synchronous reset
// empties the list. Read out loads one node per cycle from the link and node
// memories while rsp_ready stays high. A stalled result holds the sequence;
// the next request is taken once the last result is loaded and the block idles.
module array_linked_list_insert_walk_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  alliw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output alliw_pkg::rsp_type rsp_data
);
   import alliw_pkg::*;

   ctl_type ctl;
   sts_type sts;

   alliw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   alliw_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
